// ----- hdl/wcs_pkg.sv -----
package wcs_pkg;

   // fixed field widths of the request and response beats
   localparam int CMD_BITS    = 2;
   localparam int IDX_BITS    = 12;
   localparam int WEIGHT_BITS = 32;
   localparam int FRAC_BITS   = 32;
   localparam int DELTA_BITS  = 33;
   localparam int TOTAL_BITS  = 44;
   localparam int CFG_BITS    = 13;
   localparam int CFG_RESET   = 4096;

   localparam int REQ_DATA_BITS = 112;
   localparam int RSP_DATA_BITS = 56;

   // table banks along the row of cells
   localparam int LANES     = 4;
   localparam int LANE_BITS = $clog2(LANES);

   localparam int DEF_CELL_COUNT = 4096;
   localparam int DEF_SUM_WIDTH  = 44;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_ADJUST = 2'd2
   } command_type;

   // broadcast control to every cell
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic load;
      logic sub;
      logic prev_zero;
   } cell_ctl_type;

   // per-cell status back to the sequencer
   typedef struct packed {
      logic last_hit;
      logic above;
   } cell_flag_type;

endpackage

// ----- hdl/wcs_cell.sv -----
module wcs_cell import wcs_pkg::*; #(
   parameter int CELL_COUNT = DEF_CELL_COUNT,
   parameter int SUM_WIDTH  = DEF_SUM_WIDTH,
   parameter int LANE       = 0,
   localparam int ROWS      = (CELL_COUNT + LANES - 1) / LANES,
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int POS_BITS  = LANE_BITS + ROW_BITS + 1
) (
   input  logic                 clock,
   input  cell_ctl_type         ctl,
   input  logic [POS_BITS-1:0]  base,
   input  logic [POS_BITS-1:0]  range_lo,
   input  logic [POS_BITS-1:0]  range_hi,
   input  logic [SUM_WIDTH-1:0] operand,
   input  logic [SUM_WIDTH-1:0] nbr_in,
   output logic [SUM_WIDTH-1:0] nbr_out,
   output logic [SUM_WIDTH-1:0] upd_out,
   output cell_flag_type        flags
);

   logic [SUM_WIDTH-1:0] mem [ROWS];
   logic [SUM_WIDTH-1:0] rd_ff;
   logic [POS_BITS-1:0]  pos_ff;

   logic [LANE_BITS-1:0] off;
   logic [POS_BITS-1:0]  pos;
   logic                 in_table;
   logic [SUM_WIDTH-1:0] prev;
   logic [SUM_WIDTH-1:0] acc;
   logic [SUM_WIDTH:0]   sum_wide;
   logic [SUM_WIDTH-1:0] sat_sum;
   logic [SUM_WIDTH-1:0] clip_diff;
   logic [SUM_WIDTH-1:0] upd;
   logic                 wr_hit;

   // entry of the window starting at base that lives in this lane
   always_comb begin
      off      = LANE_BITS'(LANE) - base[LANE_BITS-1:0];
      pos      = base + POS_BITS'(off);
      in_table = pos < POS_BITS'(ROWS * LANES);
   end

   always_comb begin
      prev      = ctl.prev_zero ? '0 : nbr_in;
      acc       = ctl.load ? prev : rd_ff;
      sum_wide  = {1'b0, acc} + {1'b0, operand};
      sat_sum   = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
      clip_diff = (acc >= operand) ? (acc - operand) : '0;
      upd       = ctl.sub ? clip_diff : sat_sum;
      wr_hit    = ctl.wr_en && (pos_ff >= range_lo) && (pos_ff <= range_hi);
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         pos_ff <= pos;
         if (in_table) begin
            rd_ff <= mem[pos[LANE_BITS +: ROW_BITS]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         mem[pos_ff[LANE_BITS +: ROW_BITS]] <= upd;
      end
   end

   assign nbr_out        = rd_ff;
   assign upd_out        = upd;
   assign flags.last_hit = wr_hit && (pos_ff == range_hi);
   assign flags.above    = rd_ff > prev;

endmodule

// ----- hdl/wcs_scale.sv -----
module wcs_scale import wcs_pkg::*; #(
   parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
   input  logic                 clock,
   input  logic [SUM_WIDTH-1:0] total,
   input  logic [FRAC_BITS-1:0] frac,
   output logic [SUM_WIDTH-1:0] target
);

   localparam int PROD_BITS = 2 * FRAC_BITS;

   logic [PROD_BITS-1:0] prod_lo_ff, prod_lo_in;
   logic [SUM_WIDTH-1:0] prod_hi_ff, prod_hi_in;
   logic [SUM_WIDTH-1:0] target_ff, target_in;

   // floor(total * frac / 2^32) split into a high and a low partial product
   always_comb begin
      prod_lo_in = PROD_BITS'(total[FRAC_BITS-1:0]) * PROD_BITS'(frac);
      prod_hi_in = SUM_WIDTH'(total[SUM_WIDTH-1:FRAC_BITS]) * SUM_WIDTH'(frac);
      target_in  = prod_hi_ff + SUM_WIDTH'(prod_lo_ff[PROD_BITS-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      target_ff  <= target_in;
   end

   assign target = target_ff;

endmodule

// ----- hdl/weighted_cell_sampler.sv -----
// weighted cell sampler: picks table cells in proportion to their weights
// from a table of running sums held in a row of four bank cells.
// req channel: one beat per command (tuser = command). load appends a
// weight after the previous entry, sample scales the total by a 32-bit
// fraction and binary-searches the first entry above it, adjust adds a
// signed delta to every entry from the index to the last cell in use.
// rsp channel: exactly one beat per request, in request order.
// csr channel: writes cells_in_use; the user must write it only while no
// request is in flight; the block itself does not enforce this.
// load reads the predecessor entry, then writes; sample passes the two
// multiplier stages, the search probes (at most ceil(log2 n)) and the empty
// check; adjust reads and writes back the rows from the index to the end.
// the search probes one entry per cycle through the registered bank read
// port; adjust streams one row of four banks per cycle, read then write.
// reset clears the total, the control state and restores cells_in_use to
// 4096; table contents are undefined until loaded.
// a stalled rsp beat holds in the output register while the next request
// is taken and worked on; its result waits until the register drains.
module weighted_cell_sampler import wcs_pkg::*; #(
   parameter int CELL_COUNT = DEF_CELL_COUNT,
   parameter int SUM_WIDTH  = DEF_SUM_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   // request: [11:0] cell_index, [43:12] weight, [75:44] random_fraction,
   // [108:76] delta, [111:109] zero
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] command
   input  logic [CMD_BITS-1:0]      req_tuser,
   // response: [11:0] selected_cell, [55:12] total_weight_out
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] empty_cell
   output logic                     rsp_tuser,
   // cells_in_use register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CFG_BITS-1:0]      csr_data
);

   localparam int ROWS      = (CELL_COUNT + LANES - 1) / LANES;
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int POS_BITS  = LANE_BITS + ROW_BITS + 1;
   localparam int IW        = $clog2(CELL_COUNT);
   localparam int CNT_BITS  = $clog2(CELL_COUNT + 1);
   localparam int NW        = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int XW        = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_LOAD_RD = 10'b00_0000_0010,
      ST_LOAD_WR = 10'b00_0000_0100,
      ST_MUL     = 10'b00_0000_1000,
      ST_ADD     = 10'b00_0001_0000,
      ST_SEARCH  = 10'b00_0010_0000,
      ST_EMPTY   = 10'b00_0100_0000,
      ST_ADJ     = 10'b00_1000_0000,
      ST_ADJ_END = 10'b01_0000_0000,
      ST_PUSH    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // request fields held for the whole command
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [WEIGHT_BITS-1:0] weight_ff;
   logic [FRAC_BITS-1:0]   frac_ff;
   logic [DELTA_BITS-1:0]  delta_ff;

   logic [SUM_WIDTH-1:0]   total_ff, total_in;
   logic [CFG_BITS-1:0]    cells_ff, cells_in;

   // search bounds and probe
   logic [IW-1:0]          lo_ff, lo_in;
   logic [IW-1:0]          hi_ff, hi_in;
   logic [IW-1:0]          mid_ff, mid_in;
   logic                   pend_ff, pend_in;
   logic                   prev_zero_ff, prev_zero_in;
   logic [POS_BITS-1:0]    adj_base_ff, adj_base_in;

   logic [IDX_BITS-1:0]    res_sel_ff, res_sel_in;
   logic                   res_empty_ff, res_empty_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]    rsp_sel_ff, rsp_sel_in;
   logic [TOTAL_BITS-1:0]  rsp_total_ff, rsp_total_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   // cell row
   cell_ctl_type           ctl;
   logic [POS_BITS-1:0]    base;
   logic [POS_BITS-1:0]    range_lo;
   logic [POS_BITS-1:0]    range_hi;
   logic [SUM_WIDTH-1:0]   operand;
   logic [SUM_WIDTH-1:0]   lane_data [LANES];
   logic [SUM_WIDTH-1:0]   lane_upd [LANES];
   cell_flag_type          lane_flag [LANES];
   logic [LANES-1:0]       last_hits;

   logic                   req_accept;
   logic [IDX_BITS-1:0]    req_idx;
   command_type            req_cmd;
   logic [CNT_BITS-1:0]    n_cnt;
   logic [IW-1:0]          last_idx;
   logic [POS_BITS-1:0]    last_pos;
   logic                   req_idx_ok;
   logic [SUM_WIDTH-1:0]   target;
   logic [IW-1:0]          lo_step;
   logic [IW-1:0]          hi_step;
   logic [IW:0]            mid_sum;
   logic [POS_BITS-1:0]    mid_pos;
   logic [POS_BITS-1:0]    lo_pos;
   logic [SUM_WIDTH-1:0]   mid_data;
   logic [DELTA_BITS-1:0]  mag;
   logic                   out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_idx    = req_tdata[IDX_BITS-1:0];
   assign req_cmd    = command_type'(req_tuser);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // effective cell count, clamped to 1..CELL_COUNT
   always_comb begin
      if (cells_ff == '0) begin
         n_cnt = CNT_BITS'(1);
      end else if (NW'(cells_ff) > NW'(CELL_COUNT)) begin
         n_cnt = CNT_BITS'(CELL_COUNT);
      end else begin
         n_cnt = CNT_BITS'(cells_ff);
      end
      last_idx   = IW'(n_cnt - CNT_BITS'(1));
      last_pos   = POS_BITS'(last_idx);
      req_idx_ok = XW'(req_idx) < XW'(n_cnt);
   end

   // adjust magnitude from the two's complement delta
   assign mag = delta_ff[DELTA_BITS-1] ? (~delta_ff + DELTA_BITS'(1)) : delta_ff;

   assign cells_in = csr_valid ? csr_data : cells_ff;

   // one search step: narrow the bounds with the probe just read
   always_comb begin
      mid_pos  = POS_BITS'(mid_ff);
      lo_pos   = POS_BITS'(lo_ff);
      mid_data = lane_data[mid_pos[LANE_BITS-1:0]];
      lo_step  = lo_ff;
      hi_step  = hi_ff;
      if (pend_ff) begin
         if (target < mid_data) begin
            hi_step = mid_ff;
         end else begin
            lo_step = IW'(mid_ff + 1'b1);
         end
      end
      mid_sum = (IW+1)'(lo_step) + (IW+1)'(hi_step);
   end

   // total follows the entry written at the top of the write range
   always_comb begin
      total_in = total_ff;
      for (int k = 0; k < LANES; k++) begin
         last_hits[k] = lane_flag[k].last_hit;
         if (lane_flag[k].last_hit) begin
            total_in = lane_upd[k];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pend_in      = pend_ff;
      prev_zero_in = prev_zero_ff;
      adj_base_in  = adj_base_ff;
      res_sel_in   = res_sel_ff;
      res_empty_in = res_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sel_in   = rsp_sel_ff;
      rsp_total_in = rsp_total_ff;
      rsp_empty_in = rsp_empty_ff;
      ctl           = '0;
      ctl.prev_zero = prev_zero_ff;
      base         = '0;
      range_lo     = POS_BITS'(idx_ff);
      range_hi     = POS_BITS'(idx_ff);
      operand      = SUM_WIDTH'(weight_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               idx_in       = req_idx;
               lo_in        = '0;
               hi_in        = last_idx;
               pend_in      = 1'b0;
               prev_zero_in = (req_idx == '0);
               adj_base_in  = (POS_BITS'(req_idx) >> LANE_BITS) << LANE_BITS;
               res_sel_in   = req_idx;
               res_empty_in = 1'b0;
               case (req_cmd)
                  CMD_LOAD: begin
                     state_in = req_idx_ok ? ST_LOAD_RD : ST_PUSH;
                  end
                  CMD_SAMPLE: begin
                     state_in = ST_MUL;
                  end
                  CMD_ADJUST: begin
                     state_in = req_idx_ok ? ST_ADJ : ST_PUSH;
                  end
                  default: begin
                     state_in = ST_PUSH;
                  end
               endcase
            end
         end

         // read the predecessor entry; its lane hands it to the next lane
         ST_LOAD_RD: begin
            ctl.rd_en = 1'b1;
            base      = (idx_ff == '0) ? '0 : POS_BITS'(idx_ff) - POS_BITS'(1);
            state_in  = ST_LOAD_WR;
         end

         ST_LOAD_WR: begin
            ctl.wr_en = 1'b1;
            ctl.load  = 1'b1;
            state_in  = ST_PUSH;
         end

         // scaled target through the two multiplier stages
         ST_MUL: begin
            state_in = ST_ADD;
         end

         ST_ADD: begin
            state_in = ST_SEARCH;
         end

         ST_SEARCH: begin
            lo_in     = lo_step;
            hi_in     = hi_step;
            ctl.rd_en = 1'b1;
            if (lo_step < hi_step) begin
               mid_in  = mid_sum[IW:1];
               base    = POS_BITS'(mid_sum[IW:1]);
               pend_in = 1'b1;
            end else begin
               // fetch the chosen entry and its predecessor for the empty check
               prev_zero_in  = (lo_step == '0);
               ctl.prev_zero = 1'b0;
               base     = (lo_step == '0) ? '0 : POS_BITS'(lo_step) - POS_BITS'(1);
               pend_in  = 1'b0;
               state_in = ST_EMPTY;
            end
         end

         ST_EMPTY: begin
            res_sel_in   = IDX_BITS'(lo_ff);
            res_empty_in = !lane_flag[lo_pos[LANE_BITS-1:0]].above;
            state_in     = ST_PUSH;
         end

         // one table row per cycle: read this row, write back the last one
         ST_ADJ: begin
            ctl.rd_en   = 1'b1;
            ctl.wr_en   = pend_ff;
            ctl.sub     = delta_ff[DELTA_BITS-1];
            base        = adj_base_ff;
            range_hi    = last_pos;
            operand     = SUM_WIDTH'(mag);
            pend_in     = 1'b1;
            adj_base_in = adj_base_ff + POS_BITS'(LANES);
            if (adj_base_ff[POS_BITS-1:LANE_BITS] == last_pos[POS_BITS-1:LANE_BITS]) begin
               state_in = ST_ADJ_END;
            end
         end

         ST_ADJ_END: begin
            ctl.wr_en = 1'b1;
            ctl.sub   = delta_ff[DELTA_BITS-1];
            range_hi  = last_pos;
            operand   = SUM_WIDTH'(mag);
            pend_in   = 1'b0;
            state_in  = ST_PUSH;
         end

         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = res_sel_ff;
               rsp_total_in = TOTAL_BITS'(total_ff);
               rsp_empty_in = res_empty_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         cells_ff     <= CFG_BITS'(CFG_RESET);
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         cells_ff     <= cells_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         weight_ff <= req_tdata[IDX_BITS +: WEIGHT_BITS];
         frac_ff   <= req_tdata[IDX_BITS + WEIGHT_BITS +: FRAC_BITS];
         delta_ff  <= req_tdata[IDX_BITS + WEIGHT_BITS + FRAC_BITS +: DELTA_BITS];
      end
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      prev_zero_ff <= prev_zero_in;
      adj_base_ff  <= adj_base_in;
      res_sel_ff   <= res_sel_in;
      res_empty_ff <= res_empty_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_total_ff <= rsp_total_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   wcs_scale #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_scale (
      .clock  (clock),
      .total  (total_ff),
      .frac   (frac_ff),
      .target (target)
   );

   // row of bank cells; each hands its read data to the next lane
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      wcs_cell #(
         .CELL_COUNT (CELL_COUNT),
         .SUM_WIDTH  (SUM_WIDTH),
         .LANE       (k)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .base     (base),
         .range_lo (range_lo),
         .range_hi (range_hi),
         .operand  (operand),
         .nbr_in   (lane_data[(k + LANES - 1) % LANES]),
         .nbr_out  (lane_data[k]),
         .upd_out  (lane_upd[k]),
         .flags    (lane_flag[k])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_sel_ff};
   assign rsp_tuser  = rsp_empty_ff;

   // search bounds never cross
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff <= hi_ff))
      else $error("search bounds crossed");

   // only one lane may carry the entry that sets the total
   a_one_last: assert property (@(posedge clock) disable iff (reset)
      $onehot0(last_hits))
      else $error("several lanes hit the last entry");

   // a response beat only appears from the push step
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_PUSH))
      else $error("response beat without push");

   // an accepted request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer idle");

   // sample commands never write the table
   a_sample_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEARCH) || (state_ff == ST_EMPTY)) |-> !ctl.wr_en)
      else $error("table write during sample");

endmodule
